// ===== design/i2cm_pkg.sv =====
// Shared types, command codes and phase tables for the I2C master byte engine.
// Used by i2cm_front, i2cm_back and the i2c_master_byte_engine top level.
// No dependencies.
package i2cm_pkg;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [15:0] PHASE_TICKS_RST = 16'd5;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] command;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_level;
    } tick_word_t;

    function automatic logic [4:0] phase_count(input logic [1:0] cmd);
        logic [4:0] n;
        unique case (cmd)
            CMD_WRITE: n = 5'd27;
            CMD_READ:  n = 5'd19;
            default:   n = 5'd3;
        endcase
        return n;
    endfunction

    // Returns {scl_low, sda_low} after the given phase begins.
    function automatic logic [1:0] phase_drive(
        input logic [1:0] cmd,
        input logic [4:0] s,
        input logic [7:0] shift,
        input logic       ack,
        input logic       scl_in,
        input logic       sda_in
    );
        logic [8:0] prod;
        logic [2:0] q;
        logic [4:0] r;
        logic [1:0] d;
        prod = {4'b0, s} * 9'd11;
        q    = prod[7:5];
        r    = s - ({2'b0, q} * 5'd3);
        d    = {scl_in, sda_in};
        unique case (cmd)
            CMD_START: begin
                if (s == 5'd0) d = 2'b00;
                else if (s == 5'd1) d = {scl_in, 1'b1};
                else d = {1'b1, sda_in};
            end
            CMD_STOP: begin
                if (s == 5'd0) d = {scl_in, 1'b1};
                else if (s == 5'd1) d = {1'b0, sda_in};
                else d = {scl_in, 1'b0};
            end
            CMD_WRITE: begin
                if (s < 5'd24) begin
                    if (r == 5'd0) d = {scl_in, ~shift[3'd7 - q]};
                    else if (r == 5'd1) d = {1'b0, sda_in};
                    else d = {1'b1, sda_in};
                end else if (s == 5'd24) d = {scl_in, 1'b0};
                else if (s == 5'd25) d = {1'b0, sda_in};
                else d = {1'b1, sda_in};
            end
            default: begin
                if (s == 5'd0) d = {scl_in, 1'b0};
                else if (s < 5'd16) d = {~s[0], sda_in};
                else if (s == 5'd16) d = {1'b1, ack};
                else if (s == 5'd17) d = {1'b0, sda_in};
                else d = {1'b1, sda_in};
            end
        endcase
        return d;
    endfunction

endpackage

// ===== design/i2cm_front.sv =====
// Front end of the I2C master byte engine: takes input words, unpacks them
// and holds them in a short queue for the back end. Depends on i2cm_pkg.
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,
    input  logic [2:0]   s_tuser,
    output logic         q_valid,
    output tick_word_t   q_word,
    input  logic         q_pop
);

    tick_word_t     mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;
    tick_word_t     in_word;
    logic           push, pop;

    always_comb begin
        in_word.cmd_valid = s_tuser[0];
        in_word.command   = s_tuser[2:1];
        in_word.tx_byte   = s_tdata[7:0];
        in_word.send_ack  = s_tdata[8];
        in_word.sda_level = s_tdata[9];
    end

    assign s_tready = (count_reg != (QAW+1)'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_word   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_word;
        end
    end

endmodule

// ===== design/i2cm_back.sv =====
// Back end of the I2C master byte engine: runs the phase sequencer one word
// at a time and holds the result in the output register. Depends on i2cm_pkg.
module i2cm_back
    import i2cm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    input  logic         q_valid,
    input  tick_word_t   q_word,
    output logic         q_pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata
);

    logic [15:0] phase_ticks_reg;
    logic [15:0] timer_reg, timer_next;
    logic [4:0]  step_reg, step_next;
    logic [7:0]  shift_reg, shift_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic        busy_reg, busy_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        ack_reg, ack_next;
    logic        done_reg, done_next;
    logic [7:0]  rx_reg, rx_next;
    logic        mvalid_reg;

    logic [15:0] len;
    logic [15:0] tinc;
    logic        phase_end;
    logic [1:0]  drv_cmd;
    logic [4:0]  drv_step;
    logic [7:0]  drv_shift;
    logic        drv_ack;

    assign q_pop = q_valid && (!mvalid_reg || m_tready);

    assign len       = (phase_ticks_reg == 16'd0) ? 16'd1 : phase_ticks_reg;
    assign tinc      = timer_reg + 16'd1;
    assign phase_end = (tinc >= len) || (tinc == 16'd0);

    always_comb begin
        timer_next = timer_reg;
        step_next  = step_reg;
        shift_next = shift_reg;
        cmd_next   = cmd_reg;
        busy_next  = busy_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        done_next  = 1'b0;
        drv_cmd    = cmd_reg;
        drv_step   = step_reg;
        drv_shift  = shift_reg;
        drv_ack    = ack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        if (!busy_reg) begin
            if (q_word.cmd_valid) begin
                busy_next  = 1'b1;
                cmd_next   = q_word.command;
                step_next  = 5'd0;
                timer_next = 16'd0;
                ack_next   = q_word.send_ack;
                if (q_word.command == CMD_WRITE) begin
                    shift_next = q_word.tx_byte;
                end else if (q_word.command == CMD_READ) begin
                    shift_next = 8'd0;
                end
                drv_cmd   = q_word.command;
                drv_step  = 5'd0;
                drv_shift = shift_next;
                drv_ack   = q_word.send_ack;
                {scl_next, sda_next} = phase_drive(drv_cmd, drv_step, drv_shift, drv_ack,
                                                   scl_reg, sda_reg);
            end
        end else if (phase_end) begin
            if (cmd_reg == CMD_READ && step_reg < 5'd16 && step_reg[0]) begin
                shift_next = {shift_reg[6:0], q_word.sda_level};
            end
            timer_next = 16'd0;
            step_next  = step_reg + 5'd1;
            if (step_next >= phase_count(cmd_reg)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                step_next = 5'd0;
                if (cmd_reg == CMD_READ) begin
                    sda_next = 1'b0;
                    rx_next  = shift_next;
                end
            end else begin
                drv_step  = step_next;
                drv_shift = shift_next;
                {scl_next, sda_next} = phase_drive(drv_cmd, drv_step, drv_shift, drv_ack,
                                                   scl_reg, sda_reg);
            end
        end else begin
            timer_next = tinc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RST;
            timer_reg       <= '0;
            step_reg        <= '0;
            shift_reg       <= '0;
            cmd_reg         <= CMD_START;
            busy_reg        <= 1'b0;
            scl_reg         <= 1'b0;
            sda_reg         <= 1'b0;
            ack_reg         <= 1'b0;
            done_reg        <= 1'b0;
            rx_reg          <= '0;
            mvalid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                phase_ticks_reg <= cfg_wr_data;
            end
            if (q_pop) begin
                timer_reg <= timer_next;
                step_reg  <= step_next;
                shift_reg <= shift_next;
                cmd_reg   <= cmd_next;
                busy_reg  <= busy_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                ack_reg   <= ack_next;
                done_reg  <= done_next;
                rx_reg    <= rx_next;
            end
            if (q_pop) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {4'b0, rx_reg, done_reg, busy_reg, sda_reg, scl_reg};

endmodule

// ===== design/i2c_master_byte_engine.sv =====
// Top level of the I2C master byte engine: front queue plus phase sequencer.
// Depends on i2cm_pkg, i2cm_front and i2cm_back.
//
//  channel  direction  contents
//  s_       in         one tick word: command, byte, ack choice, SDA sample
//  m_       out        one result word per tick word: line drives, status, read byte
//  cfg_     in         phase length in ticks
//
// One word is accepted and one result delivered per clock cycle, sustained, while m_tready stays high.
// An accepted word passes through the queue into the result register; the
// four-word queue between front and sequencer absorbs output stalls.
// Reset clears the queue and the sequencer and sets the phase length to five.
module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,  // tx_byte[7:0], send_ack[8], sda_level[9], zero
    input  logic [2:0]   s_tuser,  // cmd_valid[0], command[2:1]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata   // scl_drive_low, sda_drive_low, busy_res, done_res,
                                   // read_byte[11:4], zero
);

    tick_word_t q_word;
    logic       q_valid;
    logic       q_pop;

    i2cm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_word   (q_word),
        .q_pop    (q_pop)
    );

    i2cm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_word      (q_word),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
